[hw/rtl/multi_slot_tick_timer_top_defines.svh]
// ============================================================================
// Assertion macros for the multi-slot tick timer
// Shared helpers that wrap concurrent assertions on clk with reset disable.
// ============================================================================
`ifndef MULTI_SLOT_TICK_TIMER_TOP_DEFINES_SVH
`define MULTI_SLOT_TICK_TIMER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define MSTT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define MSTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mstt_pkg.sv]
// ============================================================================
// Multi-slot tick timer package
// Command codes and the per-slot flag layout.
// ============================================================================
`timescale 1ns / 1ps

package mstt_pkg;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_APPEND     = 3'd1,
        KIND_FREE       = 3'd2,
        KIND_SET_ACTIVE = 3'd3,
        KIND_SET_VALUE  = 3'd4
    } kind_t;

    typedef struct packed {
        logic one_shot;
        logic count_up;
        logic active;
    } slot_flags_t;

endpackage

[hw/rtl/mstt_ram.sv]
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ============================================================================
`timescale 1ns / 1ps

module mstt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/multi_slot_tick_timer_top.sv]
// ============================================================================
// Multi-slot tick timer
// A table of timer slots stepped by tick items, managed by command items.
// ============================================================================
// Usage:
// The input channel (in_valid / in_stall) carries one command item: tick,
// append, free, set active or set value. The output channel (out_valid /
// out_stall) returns exactly one result item per command item.
// Counts and reload values live in two memories indexed by slot; flags, the
// free mask and the active total live in flip-flops.
// Append, free, set active and set value complete at once: the result is
// registered at the accepting edge and shows on the next cycle.
// A tick walks every slot through the memories, reading one slot per cycle
// and writing it back in the next cycle, once the registered reads of the
// count and reload memories have returned it; the result follows the walk.
// No new item is accepted during a tick walk, or while the result register
// holds an item that the receiver stalls; a stall simply holds the result.
// Reset frees every slot, clears all flags and the active total. The count
// and reload memories are not cleared; append writes both before use.
// ============================================================================
`timescale 1ns / 1ps

`include "multi_slot_tick_timer_top_defines.svh"

module multi_slot_tick_timer_top #(
    parameter int NUM_SLOTS   = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [4:0]  slot,
    input  logic        active,
    input  logic        count_up,
    input  logic        one_shot,
    input  logic [31:0] value,
    input  logic [31:0] reload,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] expired_mask,
    output logic [4:0]  slot_index,
    output logic        append_ok,
    output logic [5:0]  active_count
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SEQ_W = $clog2(NUM_SLOTS + 1);
    localparam int ACT_W = $clog2(NUM_SLOTS + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_TICK
    } state_t;

    state_t                state_reg, state_next;
    logic [SEQ_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [NUM_SLOTS-1:0]  mask_reg, mask_next;
    mstt_pkg::slot_flags_t flags_reg [NUM_SLOTS];
    mstt_pkg::slot_flags_t flags_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  free_reg, free_next;
    logic [ACT_W-1:0]      act_total_reg, act_total_next;

    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           expired_mask_reg, expired_mask_next;
    logic [4:0]            slot_index_reg, slot_index_next;
    logic                  append_ok_reg, append_ok_next;
    logic [5:0]            active_count_reg, active_count_next;

    logic                  cnt_we, rel_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, rel_wdata, cnt_rdata, rel_rdata;

    logic                  accept;
    logic [COUNT_WIDTH-1:0] val_c, rel_c;
    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_idx;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;

    mstt_pkg::slot_flags_t cur_flags;
    logic                  step;
    logic                  hit;
    logic [COUNT_WIDTH-1:0] cnt_inc, cnt_new;
    logic                  act_old, act_new;
    logic                  load_out;
    logic [NUM_SLOTS-1:0]  active_vec;

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign val_c    = COUNT_WIDTH'(value);
    assign rel_c    = COUNT_WIDTH'(reload);
    assign slot_ok  = ({1'b0, slot} < 6'(NUM_SLOTS));
    assign slot_idx = slot[IDX_W-1:0];
    assign ram_raddr = rd_cnt_reg[IDX_W-1:0];

    // Lowest free slot wins.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            active_vec[i] = flags_reg[i].active;
        end
    end

    // Second stage of the tick walk: the slot read last cycle is stepped.
    assign cur_flags = flags_reg[pend_idx_reg];
    assign step      = pend_vld_reg && !free_reg[pend_idx_reg] && cur_flags.active;
    assign cnt_inc   = cnt_rdata + 1'b1;

    always_comb
    begin
        if (cur_flags.count_up)
        begin
            // A count at or above its reload is not stepped; it fires only when equal.
            if (cnt_rdata < rel_rdata)
            begin
                hit     = (cnt_inc == rel_rdata);
                cnt_new = hit ? '0 : cnt_inc;
            end
            else
            begin
                hit     = (cnt_rdata == rel_rdata);
                cnt_new = hit ? '0 : cnt_rdata;
            end
        end
        else
        begin
            hit     = (cnt_rdata[COUNT_WIDTH-1:1] == '0);
            cnt_new = hit ? rel_rdata : (cnt_rdata - 1'b1);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        rd_cnt_next       = rd_cnt_reg;
        pend_vld_next     = pend_vld_reg;
        pend_idx_next     = pend_idx_reg;
        mask_next         = mask_reg;
        flags_next        = flags_reg;
        free_next         = free_reg;
        out_valid_next    = out_valid_reg;
        expired_mask_next = expired_mask_reg;
        slot_index_next   = slot_index_reg;
        append_ok_next    = append_ok_reg;
        active_count_next = active_count_reg;
        cnt_we            = 1'b0;
        rel_we            = 1'b0;
        ram_waddr         = pend_idx_reg;
        cnt_wdata         = cnt_new;
        rel_wdata         = rel_c;
        act_old           = 1'b0;
        act_new           = 1'b0;
        load_out          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    expired_mask_next = '0;
                    slot_index_next   = '0;
                    append_ok_next    = 1'b0;
                    load_out          = 1'b1;
                    unique case (kind)
                        mstt_pkg::KIND_TICK:
                        begin
                            load_out      = 1'b0;
                            state_next    = ST_TICK;
                            rd_cnt_next   = '0;
                            pend_vld_next = 1'b0;
                            mask_next     = '0;
                        end
                        mstt_pkg::KIND_APPEND:
                        begin
                            if (free_found)
                            begin
                                cnt_we    = 1'b1;
                                rel_we    = 1'b1;
                                ram_waddr = free_idx;
                                cnt_wdata = val_c;
                                rel_wdata = rel_c;
                                act_old   = flags_reg[free_idx].active;
                                act_new   = active;
                                flags_next[free_idx] = '{one_shot: one_shot,
                                                         count_up: count_up,
                                                         active:   active};
                                free_next[free_idx] = 1'b0;
                                slot_index_next     = 5'(free_idx);
                                append_ok_next      = 1'b1;
                            end
                        end
                        mstt_pkg::KIND_FREE:
                        begin
                            if (slot_ok)
                            begin
                                free_next[slot_idx]         = 1'b1;
                                act_old                     = flags_reg[slot_idx].active;
                                flags_next[slot_idx].active = 1'b0;
                            end
                        end
                        mstt_pkg::KIND_SET_ACTIVE:
                        begin
                            if (slot_ok)
                            begin
                                act_old                     = flags_reg[slot_idx].active;
                                act_new                     = active;
                                flags_next[slot_idx].active = active;
                            end
                        end
                        mstt_pkg::KIND_SET_VALUE:
                        begin
                            if (slot_ok)
                            begin
                                ram_waddr = slot_idx;
                                cnt_we    = 1'b1;
                                // An up-counter takes the value as its new reload.
                                if (flags_reg[slot_idx].count_up)
                                begin
                                    rel_we    = 1'b1;
                                    rel_wdata = val_c;
                                    cnt_wdata = '0;
                                end
                                else
                                begin
                                    cnt_wdata = val_c;
                                end
                                act_old                     = flags_reg[slot_idx].active;
                                act_new                     = active;
                                flags_next[slot_idx].active = active;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                if (step)
                begin
                    cnt_we    = 1'b1;
                    ram_waddr = pend_idx_reg;
                    cnt_wdata = cnt_new;
                    if (hit)
                    begin
                        mask_next[pend_idx_reg] = 1'b1;
                        if (cur_flags.one_shot)
                        begin
                            free_next[pend_idx_reg]         = 1'b1;
                            flags_next[pend_idx_reg].active = 1'b0;
                            act_old                         = 1'b1;
                        end
                    end
                end
                if (rd_cnt_reg < SEQ_W'(NUM_SLOTS))
                begin
                    pend_vld_next = 1'b1;
                    pend_idx_next = rd_cnt_reg[IDX_W-1:0];
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                else
                begin
                    pend_vld_next     = 1'b0;
                    state_next        = ST_IDLE;
                    load_out          = 1'b1;
                    expired_mask_next = 32'(mask_next);
                    slot_index_next   = '0;
                    append_ok_next    = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        act_total_next = act_total_reg + ACT_W'(act_new) - ACT_W'(act_old);
        if (load_out)
        begin
            out_valid_next    = 1'b1;
            active_count_next = 6'(act_total_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_cnt_reg       <= '0;
            pend_vld_reg     <= 1'b0;
            pend_idx_reg     <= '0;
            mask_reg         <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                flags_reg[i] <= '0;
            end
            free_reg         <= '1;
            act_total_reg    <= '0;
            out_valid_reg    <= 1'b0;
            expired_mask_reg <= '0;
            slot_index_reg   <= '0;
            append_ok_reg    <= 1'b0;
            active_count_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_cnt_reg       <= rd_cnt_next;
            pend_vld_reg     <= pend_vld_next;
            pend_idx_reg     <= pend_idx_next;
            mask_reg         <= mask_next;
            flags_reg        <= flags_next;
            free_reg         <= free_next;
            act_total_reg    <= act_total_next;
            out_valid_reg    <= out_valid_next;
            expired_mask_reg <= expired_mask_next;
            slot_index_reg   <= slot_index_next;
            append_ok_reg    <= append_ok_next;
            active_count_reg <= active_count_next;
        end
    end

    mstt_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (ram_waddr),
        .wdata (cnt_wdata),
        .raddr (ram_raddr),
        .rdata (cnt_rdata)
    );

    mstt_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_reload_ram (
        .clk   (clk),
        .we    (rel_we),
        .waddr (ram_waddr),
        .wdata (rel_wdata),
        .raddr (ram_raddr),
        .rdata (rel_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign expired_mask = expired_mask_reg;
    assign slot_index   = slot_index_reg;
    assign append_ok    = append_ok_reg;
    assign active_count = active_count_reg;

    `MSTT_ASSERT_ALWAYS(a_active_total,
        $countones(active_vec) == int'(act_total_reg),
        "active total out of step with the active flags")
    `MSTT_ASSERT_NEXT(a_tick_result,
        (state_reg == ST_TICK) && (rd_cnt_reg == SEQ_W'(NUM_SLOTS)),
        out_valid_reg && (state_reg == ST_IDLE),
        "tick walk ended without a result")
    `MSTT_ASSERT_NEXT(a_one_shot_freed,
        step && hit && cur_flags.one_shot,
        free_reg[$past(pend_idx_reg)] && !flags_reg[$past(pend_idx_reg)].active,
        "expired one-shot slot not released")

endmodule

[tb/multi_slot_tick_timer_top_tb.sv]
// ============================================================================
// Multi-slot tick timer testbench
// Sends directed and random command items through the valid/stall input
// channel and checks every result item against a timer table kept in the
// bench. The input channel idles and the output channel stalls at random.
// ============================================================================
`timescale 1ns / 1ps

module multi_slot_tick_timer_top_tb;
    import mstt_pkg::*;

    localparam int         SLOTS            = 32;
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam int         RANDOM_ITEMS     = 1725;
    localparam int         PHASE_LEN        = 250;
    localparam int         TAIL_CYCLES      = 80;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic        active;
        logic        count_up;
        logic        one_shot;
        logic [31:0] value;
        logic [31:0] reload;
        logic        drain;
    } timer_cmd_t;

    typedef struct packed {
        logic [31:0] expired_mask;
        logic [4:0]  slot_index;
        logic        append_ok;
        logic [5:0]  active_count;
    } timer_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  kind     = '0;
    logic [4:0]  slot     = '0;
    logic        active   = 1'b0;
    logic        count_up = 1'b0;
    logic        one_shot = 1'b0;
    logic [31:0] value    = '0;
    logic [31:0] reload   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] expired_mask;
    logic [4:0]  slot_index;
    logic        append_ok;
    logic [5:0]  active_count;

    // Timer table as the bench sees it.
    logic [31:0] count_tbl [SLOTS];
    logic [31:0] reload_tbl [SLOTS];
    slot_flags_t flag_tbl [SLOTS];
    logic [31:0] free_slots;

    timer_cmd_t    cmd_backlog [$];
    timer_result_t results_due [$];

    int error_count = 0;
    int n_items     = 0;
    int n_ticks     = 0;
    int n_appends   = 0;
    int n_refused   = 0;
    int n_ignored   = 0;
    int n_fired     = 0;
    int n_checked   = 0;
    int gap_left    = 0;
    int tx_calm     = 0;
    int stall_left  = 0;
    int rx_calm     = 0;

    multi_slot_tick_timer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .slot         (slot),
        .active       (active),
        .count_up     (count_up),
        .one_shot     (one_shot),
        .value        (value),
        .reload       (reload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .expired_mask (expired_mask),
        .slot_index   (slot_index),
        .append_ok    (append_ok),
        .active_count (active_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Applies one command to the bench table and returns the result it causes.
    function automatic timer_result_t step_timer_table(input logic [2:0] k,
                                                       input logic [4:0] s,
                                                       input logic act,
                                                       input logic up,
                                                       input logic once,
                                                       input logic [31:0] val,
                                                       input logic [31:0] rel);
        timer_result_t r;
        logic          hit;
        r = '0;
        case (k)
            KIND_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!free_slots[i] && flag_tbl[i].active)
                    begin
                        hit = 1'b0;
                        if (flag_tbl[i].count_up)
                        begin
                            if (count_tbl[i] < reload_tbl[i])
                                count_tbl[i] = count_tbl[i] + 32'd1;
                            if (count_tbl[i] == reload_tbl[i])
                            begin
                                hit          = 1'b1;
                                count_tbl[i] = '0;
                            end
                        end
                        else
                        begin
                            if (count_tbl[i] != '0)
                                count_tbl[i] = count_tbl[i] - 32'd1;
                            if (count_tbl[i] == '0)
                            begin
                                hit          = 1'b1;
                                count_tbl[i] = reload_tbl[i];
                            end
                        end
                        if (hit)
                        begin
                            r.expired_mask[i] = 1'b1;
                            if (flag_tbl[i].one_shot)
                            begin
                                free_slots[i]      = 1'b1;
                                flag_tbl[i].active = 1'b0;
                            end
                        end
                    end
                end
            end
            KIND_APPEND:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!r.append_ok && free_slots[i])
                    begin
                        count_tbl[i]         = val;
                        reload_tbl[i]        = rel;
                        flag_tbl[i].active   = act;
                        flag_tbl[i].count_up = up;
                        flag_tbl[i].one_shot = once;
                        free_slots[i]        = 1'b0;
                        r.slot_index         = 5'(i);
                        r.append_ok          = 1'b1;
                    end
                end
            end
            KIND_FREE:
            begin
                free_slots[s]      = 1'b1;
                flag_tbl[s].active = 1'b0;
            end
            KIND_SET_ACTIVE:
            begin
                flag_tbl[s].active = act;
            end
            KIND_SET_VALUE:
            begin
                // An up-counter takes the value as its new terminal count.
                if (flag_tbl[s].count_up)
                begin
                    reload_tbl[s] = val;
                    count_tbl[s]  = '0;
                end
                else
                begin
                    count_tbl[s] = val;
                end
                flag_tbl[s].active = act;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < SLOTS; i++)
            r.active_count = r.active_count + 6'(flag_tbl[i].active);
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 6);
        else if (r < 85)
            return $urandom_range(7, 40);
        else if (r < 93)
            return $urandom();
        else if (r < 96)
            return 32'hFFFF_FFFF;
        else if (r < 98)
            return 32'hFFFF_FFFE;
        else
            return 32'h8000_0000;
    endfunction

    function automatic timer_cmd_t make_cmd(input logic [2:0] k, input logic [4:0] s,
                                            input logic act, input logic up,
                                            input logic once, input logic [31:0] val,
                                            input logic [31:0] rel);
        timer_cmd_t c;
        c.kind     = k;
        c.slot     = s;
        c.active   = act;
        c.count_up = up;
        c.one_shot = once;
        c.value    = val;
        c.reload   = rel;
        c.drain    = 1'b0;
        return c;
    endfunction

    // Each mode weights the command kinds differently; a few percent are unused kinds.
    function automatic timer_cmd_t random_cmd(input int mode);
        timer_cmd_t c;
        int         w;
        int         t_tick;
        int         t_app;
        int         t_free;
        int         t_act;
        c = make_cmd(KIND_TICK,
                     ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 7))
                                                  : 5'($urandom_range(0, 31)),
                     $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                     $urandom_range(0, 9) < 3, pick_count(), pick_count());
        case (mode)
            0:       begin t_tick = 40; t_app = 60; t_free = 72; t_act = 84; end
            1:       begin t_tick = 25; t_app = 80; t_free = 85; t_act = 90; end
            2:       begin t_tick = 70; t_app = 82; t_free = 88; t_act = 93; end
            default: begin t_tick = 25; t_app = 55; t_free = 80; t_act = 88; end
        endcase
        w = $urandom_range(0, 99);
        if (w < t_tick)
            c.kind = KIND_TICK;
        else if (w < t_app)
            c.kind = KIND_APPEND;
        else if (w < t_free)
            c.kind = KIND_FREE;
        else if (w < t_act)
            c.kind = KIND_SET_ACTIVE;
        else if (w < 97)
            c.kind = KIND_SET_VALUE;
        else
            c.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        return c;
    endfunction

    // Driver: predicts each accepted item, then presents the next one after a gap.
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        timer_cmd_t    c;
        timer_result_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                count_tbl[i]  = '0;
                reload_tbl[i] = '0;
                flag_tbl[i]   = '0;
            end
            free_slots = '1;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                r = step_timer_table(kind, slot, active, count_up, one_shot, value, reload);
                results_due.push_back(r);
                n_items++;
                n_fired += $countones(r.expired_mask);
                if (kind == KIND_TICK)
                    n_ticks++;
                else if (kind == KIND_APPEND)
                begin
                    n_appends++;
                    if (!r.append_ok)
                        n_refused++;
                end
                else if (kind > KIND_SET_VALUE)
                    n_ignored++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain && results_due.size() != 0))
                begin
                    c = cmd_backlog.pop_front();
                    kind     <= c.kind;
                    slot     <= c.slot;
                    active   <= c.active;
                    count_up <= c.count_up;
                    one_shot <= c.one_shot;
                    value    <= c.value;
                    reload   <= c.reload;
                    in_valid <= 1'b1;
                    if (tx_calm > 0)
                    begin
                        tx_calm--;
                        gap_left = 0;
                    end
                    else
                    begin
                        gap_left = idle_len();
                        if ($urandom_range(0, 24) == 0)
                            tx_calm = 50;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks accepted results in order and stalls the output at random.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        timer_result_t e;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result item: expired_mask %h, slot_index %0d",
                           expired_mask, slot_index);
                    error_count++;
                end
                else
                begin
                    e = results_due.pop_front();
                    n_checked++;
                    if (expired_mask !== e.expired_mask)
                    begin
                        $error("expired_mask: expected %h, got %h", e.expired_mask,
                               expired_mask);
                        error_count++;
                    end
                    if (slot_index !== e.slot_index)
                    begin
                        $error("slot_index: expected %0d, got %0d", e.slot_index, slot_index);
                        error_count++;
                    end
                    if (append_ok !== e.append_ok)
                    begin
                        $error("append_ok: expected %b, got %b", e.append_ok, append_ok);
                        error_count++;
                    end
                    if (active_count !== e.active_count)
                    begin
                        $error("active_count: expected %0d, got %0d", e.active_count,
                               active_count);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (rx_calm > 0)
                    rx_calm--;
                else if ($urandom_range(0, 29) == 0)
                    rx_calm = 60;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin : stimulus
        timer_cmd_t c;
        int         made;
        int         mode;
        int         phase_left;

        // Directed opening: empty table, counters at their limits, one-shots,
        // commands on free slots and the unused kinds.
        cmd_backlog.push_back(make_cmd(KIND_TICK, 5'd0, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_APPEND, 5'd0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd3));
        cmd_backlog.push_back(make_cmd(KIND_TICK, 5'd0, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_APPEND, 5'd0, 1'b1, 1'b1, 1'b0,
                                       32'hFFFF_FFFF, 32'd5));
        cmd_backlog.push_back(make_cmd(KIND_APPEND, 5'd0, 1'b1, 1'b1, 1'b1,
                                       32'd0, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_cmd(KIND_APPEND, 5'd0, 1'b1, 1'b0, 1'b1,
                                       32'd1, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_cmd(KIND_APPEND, 5'd0, 1'b0, 1'b1, 1'b0, 32'd0, 32'd1));
        cmd_backlog.push_back(make_cmd(KIND_TICK, 5'd0, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_SET_ACTIVE, 5'd4, 1'b1, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_TICK, 5'd0, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_SET_ACTIVE, 5'd20, 1'b1, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_TICK, 5'd0, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_SET_VALUE, 5'd1, 1'b1, 1'b0, 1'b0, 32'd2, '0));
        cmd_backlog.push_back(make_cmd(KIND_SET_VALUE, 5'd0, 1'b0, 1'b0, 1'b0,
                                       32'hFFFF_FFFF, '0));
        cmd_backlog.push_back(make_cmd(KIND_FREE, 5'd20, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_FREE, 5'd2, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_APPEND, 5'd0, 1'b1, 1'b1, 1'b1, 32'd1, 32'd2));
        cmd_backlog.push_back(make_cmd(KIND_SET_VALUE, 5'd31, 1'b0, 1'b0, 1'b0, 32'd7, '0));
        cmd_backlog.push_back(make_cmd(KIND_SPARE_FIRST, 5'd1, 1'b1, 1'b0, 1'b1,
                                       32'd9, 32'd9));
        cmd_backlog.push_back(make_cmd(KIND_SPARE_MID, 5'd0, 1'b0, 1'b1, 1'b0,
                                       32'd0, 32'd0));
        cmd_backlog.push_back(make_cmd(KIND_SPARE_LAST, 5'd31, 1'b1, 1'b1, 1'b1,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_cmd(KIND_TICK, 5'd0, 1'b0, 1'b0, 1'b0, '0, '0));
        cmd_backlog.push_back(make_cmd(KIND_TICK, 5'd31, 1'b1, 1'b1, 1'b1,
                                       32'hFFFF_FFFF, 32'hFFFF_FFFF));
        cmd_backlog.push_back(make_cmd(KIND_APPEND, 5'd31, 1'b1, 1'b0, 1'b0,
                                       32'hFFFF_FFFF, 32'd0));
        cmd_backlog.push_back(make_cmd(KIND_FREE, 5'd31, 1'b0, 1'b0, 1'b0, '0, '0));

        // Random phases; the first item of each phase waits for the output to drain.
        made       = 0;
        mode       = 0;
        phase_left = 0;
        while (made < RANDOM_ITEMS)
        begin
            c = random_cmd(mode);
            if (phase_left == 0)
            begin
                mode       = $urandom_range(0, 3);
                phase_left = PHASE_LEN;
                c          = random_cmd(mode);
                c.drain    = 1'b1;
            end
            if (c.kind <= KIND_SET_VALUE)
            begin
                made++;
                phase_left--;
            end
            cmd_backlog.push_back(c);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || in_valid)
            @(negedge clk);
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d command items: %0d ticks, %0d appends (%0d refused, table full),",
                 n_items, n_ticks, n_appends, n_refused);
        $display("%0d unused kinds, %0d slot expirations, %0d result items checked.",
                 n_ignored, n_fired, n_checked);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
